FILE: rtl/afl_pkg.sv
// Shared constants, types, sine table and microprogram for the flanger block.
package afl_pkg;

  // Delay line geometry
  localparam int DELAY_LENGTH = 650;
  localparam int ADDR_W       = $clog2(DELAY_LENGTH);
  localparam int FILL_W       = $clog2(DELAY_LENGTH + 1);
  localparam int SUM_W        = ADDR_W + 1;
  localparam int HALF_LEN     = DELAY_LENGTH / 2;

  // Sample and control field widths
  localparam int SAMPLE_W = 16;
  localparam int POT_W    = 10;
  localparam int PHASE_W  = 10;
  localparam int MOD_W    = 13;
  localparam int MULB_W   = 13;
  localparam int PROD_W   = SAMPLE_W + MULB_W + 1;
  localparam int FRAC_W   = 8;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 8'hff;

  // Quarter-wave sine table: entries 0..256 of round(32767*sin(2*pi*i/1024))
  localparam int QSINE_N      = 257;
  localparam int QIDX_W       = 9;
  localparam int SINE_QUARTER = 256;
  localparam int SINE_HALF    = 512;
  localparam real SINE_AMP    = 32767.0;
  localparam real PI_R        = 3.14159265358979323846;
  localparam real PH_SCALE    = PI_R / 512.0;

  // Reciprocals of the Taylor factors (2n)(2n+1), n = 1..10
  localparam real INV_F1  = 1.0 / 6.0;
  localparam real INV_F2  = 1.0 / 20.0;
  localparam real INV_F3  = 1.0 / 42.0;
  localparam real INV_F4  = 1.0 / 72.0;
  localparam real INV_F5  = 1.0 / 110.0;
  localparam real INV_F6  = 1.0 / 156.0;
  localparam real INV_F7  = 1.0 / 210.0;
  localparam real INV_F8  = 1.0 / 272.0;
  localparam real INV_F9  = 1.0 / 342.0;
  localparam real INV_F10 = 1.0 / 420.0;

  typedef logic signed [SAMPLE_W-1:0] qsine_tab_t [QSINE_N];

  // Sine series in nested form, innermost term first
  function automatic logic signed [SAMPLE_W-1:0] afl_qsine_entry(input int i);
    real x;
    real x2;
    real s;
    x  = PH_SCALE * real'(i);
    x2 = x * x;
    s  = 1.0 - x2 * INV_F10;
    s  = 1.0 - x2 * INV_F9 * s;
    s  = 1.0 - x2 * INV_F8 * s;
    s  = 1.0 - x2 * INV_F7 * s;
    s  = 1.0 - x2 * INV_F6 * s;
    s  = 1.0 - x2 * INV_F5 * s;
    s  = 1.0 - x2 * INV_F4 * s;
    s  = 1.0 - x2 * INV_F3 * s;
    s  = 1.0 - x2 * INV_F2 * s;
    s  = 1.0 - x2 * INV_F1 * s;
    return SAMPLE_W'($rtoi(SINE_AMP * x * s + 0.5));
  endfunction

  function automatic qsine_tab_t afl_build_qsine();
    qsine_tab_t t;
    for (int i = 0; i < QSINE_N; i++) begin
      t[i] = afl_qsine_entry(i);
    end
    return t;
  endfunction

  localparam qsine_tab_t QSINE = afl_build_qsine();

  // Full-wave lookup by quarter-wave symmetry
  function automatic logic signed [SAMPLE_W-1:0] afl_sine(input logic [PHASE_W-1:0] ph);
    logic [QIDX_W-1:0]          k;
    logic [QIDX_W-1:0]          qi;
    logic signed [SAMPLE_W-1:0] v;
    k  = ph[QIDX_W-1:0];
    qi = (k > QIDX_W'(SINE_QUARTER)) ? QIDX_W'(SINE_HALF - int'(k)) : k;
    v  = QSINE[qi];
    return ph[PHASE_W-1] ? -v : v;
  endfunction

  // Delay memory control group
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } afl_mem_ctrl_t;

  // Sequencer step codes
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LFO  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MOD  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_IDX  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RDA  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RDB  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MULB = 3'd6;
  localparam logic [STEP_W-1:0] STEP_OUT  = 3'd7;

  // Hold conditions
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_IN   = 2'd1;
  localparam logic [1:0] HOLD_OUT  = 2'd2;

  // Multiplier operations
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LFO  = 2'd1;
  localparam logic [1:0] MUL_A    = 2'd2;
  localparam logic [1:0] MUL_B    = 2'd3;

  typedef struct packed {
    logic [1:0]        hold;
    logic              sample_step;
    logic [1:0]        mul_op;
    logic              idx_load;
    logic              rd_en;
    logic              out_load;
    logic [STEP_W-1:0] jump;
  } afl_ucode_t;

  // Microprogram: one control word per step
  function automatic afl_ucode_t afl_ucode(input logic [STEP_W-1:0] step);
    afl_ucode_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.hold = HOLD_IN;
        w.jump = STEP_LFO;
      end
      STEP_LFO: begin
        w.sample_step = 1'b1;
        w.jump        = STEP_MOD;
      end
      STEP_MOD: begin
        w.mul_op = MUL_LFO;
        w.jump   = STEP_IDX;
      end
      STEP_IDX: begin
        w.idx_load = 1'b1;
        w.jump     = STEP_RDA;
      end
      STEP_RDA: begin
        w.rd_en = 1'b1;
        w.jump  = STEP_RDB;
      end
      STEP_RDB: begin
        w.rd_en  = 1'b1;
        w.mul_op = MUL_A;
        w.jump   = STEP_MULB;
      end
      STEP_MULB: begin
        w.mul_op = MUL_B;
        w.jump   = STEP_OUT;
      end
      STEP_OUT: begin
        w.hold     = HOLD_OUT;
        w.out_load = 1'b1;
        w.jump     = STEP_IDLE;
      end
      default: begin
        w.jump = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/afl_delay_line.sv
// Circular mono delay memory with a fill count that reads unwritten entries as zero.
module afl_delay_line (
  input  logic                                clk,
  input  logic                                rst_n,
  input  afl_pkg::afl_mem_ctrl_t              mem_ctrl,
  input  logic [afl_pkg::ADDR_W-1:0]          wr_addr,
  input  logic signed [afl_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [afl_pkg::ADDR_W-1:0]          rd_addr,
  output logic signed [afl_pkg::SAMPLE_W-1:0] rd_data
);
  import afl_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DELAY_LENGTH];
  logic signed [SAMPLE_W-1:0] rd_raw_r;
  logic                       rd_ok_r;
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          fill_nxt;

  // Write in order from reset, so entries below the fill count hold data
  always_comb begin
    fill_nxt = fill_r;
    if (mem_ctrl.wr_en && (fill_r != FILL_W'(DELAY_LENGTH))) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_ctrl.rd_en) begin
      rd_raw_r <= mem[rd_addr];
      rd_ok_r  <= FILL_W'(rd_addr) < fill_r;
    end
  end

  // Drop data of never-written entries
  assign rd_data = rd_ok_r ? rd_raw_r : '0;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DELAY_LENGTH))
    else $error("fill count beyond delay length");
  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctrl.wr_en |-> (FILL_W'(wr_addr) < FILL_W'(DELAY_LENGTH)))
    else $error("write address out of range");
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctrl.rd_en && (FILL_W'(rd_addr) >= fill_r)) |=> (rd_data == '0))
    else $error("unwritten entry did not read as zero");
`endif

endmodule

FILE: rtl/audio_flanger_lfo_delay_unit.sv
// Top level of the stereo flanger: microcoded sequencer, shared multiplier, delay line.
//
// Usage:
//   Input channel in_*: one stereo sample plus the two sweep controls per item.
//   Result channel out_*: one flanged stereo sample per input item.
//   Each item runs through an eight-step microprogram held in a constant
//   table: capture, sine lookup and delay write, LFO scaling, read index,
//   two delay reads, two interpolation products, output. One multiplier and
//   one delay memory read port are shared by the steps, so an item is
//   finished before the next one is accepted; the result is registered in
//   the output step, and the next item is accepted while results drain.
//   The output register holds a finished result while the next item is
//   already being worked on; only the output step waits for the receiver
//   when a previous result has not been taken, and in_tready stays low then.
//   Reset (rst_n low, synchronous) clears the LFO phase, write pointer and
//   the delay line fill count; no clearing pass is needed, entries not yet
//   written since reset read as zero, and the block accepts items right away.
module audio_flanger_lfo_delay_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] left_sample, [31:16] right_sample, [41:32] sweep_depth,
  // [51:42] sweep_rate, [55:52] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] left_result, [31:16] right_result
  output logic [31:0] out_tdata
);
  import afl_pkg::*;

  // Sequencer
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  afl_ucode_t        ucw;
  logic              stall;
  logic              in_acc;

  // Datapath registers
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic [POT_W-1:0]           depth_r;
  logic [POT_W-1:0]           rate_r;
  logic [PHASE_W-1:0]         phase_r;
  logic signed [SAMPLE_W-1:0] lfo_r;
  logic signed [MOD_W-1:0]    m_r;
  logic signed [SAMPLE_W-1:0] p_r;
  logic signed [SAMPLE_W-1:0] q_r;
  logic [ADDR_W-1:0]          wp_r;
  logic [ADDR_W-1:0]          idx_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;
  logic                       out_valid_r;

  // Combinational helpers
  logic signed [SAMPLE_W-1:0] mono;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic [MULB_W-1:0]          mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [FRAC_W-1:0]          frac;
  logic [SUM_W-1:0]           idx_sum;
  logic [SUM_W-1:0]           idx_red;
  logic signed [SAMPLE_W-1:0] wet;
  afl_mem_ctrl_t              mem_ctrl;

  // Fetch control word and decide hold or jump
  assign ucw   = afl_ucode(step_r);
  assign stall = ((ucw.hold == HOLD_IN) && !in_tvalid) ||
                 ((ucw.hold == HOLD_OUT) && out_valid_r && !out_tready);
  assign step_nxt  = stall ? step_r : ucw.jump;
  assign in_tready = (ucw.hold == HOLD_IN);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_tdata[15:0];
      right_r <= in_tdata[31:16];
      depth_r <= in_tdata[41:32];
      rate_r  <= in_tdata[51:42];
    end
  end

  // Mono mix for the delay line
  assign mono = (left_r >>> 1) + (right_r >>> 1);

  // Sine lookup, phase advance and write pointer advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      wp_r    <= '0;
    end else if (ucw.sample_step) begin
      phase_r <= phase_r + PHASE_W'(1) + PHASE_W'(rate_r[POT_W-1:POT_W-2]);
      wp_r    <= (wp_r == ADDR_W'(DELAY_LENGTH - 1)) ? '0 : wp_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.sample_step) begin
      lfo_r <= afl_sine(phase_r);
    end
  end

  // Shared multiplier: operand select by control word
  assign frac = m_r[FRAC_W-1:0];

  always_comb begin
    case (ucw.mul_op)
      MUL_LFO: begin
        mul_a = lfo_r;
        mul_b = {depth_r, 3'b000};
      end
      MUL_A: begin
        mul_a = rd_data;
        mul_b = MULB_W'(FRAC_MAX - frac);
      end
      MUL_B: begin
        mul_a = rd_data;
        mul_b = MULB_W'(frac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a * $signed({1'b0, mul_b}));

  // Register products with their shifts
  always_ff @(posedge clk) begin
    if (ucw.mul_op == MUL_LFO) begin
      m_r <= prod[MOD_W+15:16];
    end
    if (ucw.mul_op == MUL_A) begin
      p_r <= prod[SAMPLE_W+7:8];
    end
    if (ucw.mul_op == MUL_B) begin
      q_r <= prod[SAMPLE_W+7:8];
    end
  end

  // Read index: middle of the line plus the coarse offset, reduced once
  assign idx_sum = SUM_W'(wp_r) + SUM_W'(HALF_LEN) +
                   {{(SUM_W - 5){m_r[MOD_W-1]}}, m_r[MOD_W-1:8]};
  assign idx_red = (idx_sum >= SUM_W'(DELAY_LENGTH)) ? idx_sum - SUM_W'(DELAY_LENGTH)
                                                    : idx_sum;

  always_ff @(posedge clk) begin
    if (ucw.idx_load) begin
      idx_r <= idx_red[ADDR_W-1:0];
    end else if (ucw.rd_en) begin
      idx_r <= (idx_r == ADDR_W'(DELAY_LENGTH - 1)) ? '0 : idx_r + ADDR_W'(1);
    end
  end

  // Delay memory
  assign mem_ctrl.wr_en = ucw.sample_step;
  assign mem_ctrl.rd_en = ucw.rd_en;

  afl_delay_line u_delay (
    .clk      (clk),
    .rst_n    (rst_n),
    .mem_ctrl (mem_ctrl),
    .wr_addr  (wp_r),
    .wr_data  (mono),
    .rd_addr  (idx_r),
    .rd_data  (rd_data)
  );

  // Mix and hold the result until taken
  assign wet = (p_r >>> 1) + (q_r >>> 1);

  always_ff @(posedge clk) begin
    if (ucw.out_load && !stall) begin
      out_left_r  <= (left_r >>> 1) + wet;
      out_right_r <= (right_r >>> 1) + wet;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ucw.out_load && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (step_r == STEP_LFO))
    else $error("accepted item did not start the program");
  a_valid_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == STEP_OUT))
    else $error("result raised outside the output step");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ucw.idx_load |=> (SUM_W'(idx_r) < SUM_W'(DELAY_LENGTH)))
    else $error("read index out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_tdata))
    else $error("pending result overwritten");
`endif

endmodule
